// ----- hdl/dmh_pkg.sv -----
// Shared types, constants and AES-128 round functions for the Davies-Meyer hash/MAC.
// No dependencies; the AES core and the top level in hdl import this package.
package dmh_pkg;

	typedef logic [127:0] blk_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_MODE    = 3'd0;
	localparam logic [2:0] REG_KEY_HI  = 3'd1;
	localparam logic [2:0] REG_KEY_LO  = 3'd2;
	localparam logic [2:0] REG_EXP_HI  = 3'd3;
	localparam logic [2:0] REG_EXP_LO  = 3'd4;

	// Mode codes; the unused code behaves as plain hash.
	localparam logic [1:0] MODE_PLAIN  = 2'd0;
	localparam logic [1:0] MODE_SIGN   = 2'd1;
	localparam logic [1:0] MODE_VERIFY = 2'd2;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [7:0] IPAD_BYTE = 8'h36;
	localparam logic [7:0] OPAD_BYTE = 8'h5c;
	localparam logic [4:0] FULL_COUNT = 5'd16;
	localparam logic [4:0] SHORT_TAIL_MAX = 5'd6;

	localparam blk_t IV = 128'h6a09e667bb67ae853c6ef372a54ff53a;
	// Final block of a 16-byte message: 0x80, zeros, length 16 little-endian.
	localparam blk_t PAD16 = 128'h80000000000000001000000000000000;

	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
		logic [4:0]  byte_count;
		logic        last_block;
	} in_item_t;

	typedef struct packed {
		logic [63:0] tag_high;
		logic [63:0] tag_low;
		logic        tag_match;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [63:0] wdata;
	} cfg_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_IPAD,
		ST_MSG,
		ST_TAIL0,
		ST_TAIL1,
		ST_OPAD,
		ST_OPAD_FIN,
		ST_OUTER,
		ST_OUTER_FIN,
		ST_DONE
	} seq_state_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte i of a block, byte 0 in the top bits.
	function automatic logic [7:0] get_byte(input blk_t b, input int i);
		return b[127 - 8*i -: 8];
	endfunction

	// Every byte of a block xored with one pad byte.
	function automatic blk_t pad_xor(input blk_t b, input logic [7:0] p);
		return b ^ {16{p}};
	endfunction

	// SubBytes, ShiftRows and, unless it is the final round, MixColumns.
	function automatic blk_t round_state(input blk_t s, input logic final_rnd);
		logic [7:0] sb [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, all;
		blk_t r;
		for (int i = 0; i < 16; i++) sb[i] = SBOX[get_byte(s, i)];
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++) t[i + 4*c] = sb[i + 4*((c + i) & 3)];
		if (!final_rnd) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				all = a0 ^ a1 ^ a2 ^ a3;
				t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
		return r;
	endfunction

	// One step of the AES-128 key schedule.
	function automatic blk_t next_key(input blk_t rk, input logic [7:0] rcon);
		logic [7:0] k [16];
		blk_t r;
		for (int i = 0; i < 16; i++) k[i] = get_byte(rk, i);
		k[0] = k[0] ^ SBOX[k[13]] ^ rcon;
		k[1] = k[1] ^ SBOX[k[14]];
		k[2] = k[2] ^ SBOX[k[15]];
		k[3] = k[3] ^ SBOX[k[12]];
		for (int i = 4; i < 16; i++) k[i] = k[i] ^ k[i-4];
		for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = k[i];
		return r;
	endfunction

endpackage

// ----- hdl/dmh_stream_if.sv -----
// Valid/ready channel carrying one payload beat, used for input, output and configuration.
// Payload type is set by the instantiating level; depends on nothing else.
interface dmh_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/dmh_aes_core.sv -----
// Round-iterative AES-128 encryption: one round and one key-schedule step per cycle.
// Depends on dmh_pkg for the S-box and round functions.
module dmh_aes_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  dmh_pkg::blk_t key,
	input  dmh_pkg::blk_t pt,
	output logic          done,
	output dmh_pkg::blk_t ct
);
	import dmh_pkg::*;

	blk_t       state_q;
	blk_t       rk_q;
	logic [3:0] rnd_q;
	logic [7:0] rcon_q;
	logic       busy_q;
	logic       done_q;
	blk_t       rk_next;
	logic       final_rnd;

	// Round datapath shared by all ten rounds.
	always_comb begin
		final_rnd = (rnd_q == 4'd10);
		rk_next   = next_key(rk_q, rcon_q);
	end

	// Round counter and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= 4'd0;
		end else begin
			done_q <= busy_q && final_rnd;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				rnd_q  <= 4'd1;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 4'd1;
				if (final_rnd) busy_q <= 1'b0;
			end
		end
	end

	// Cipher state and round key.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			state_q <= pt ^ key;
			rk_q    <= key;
			rcon_q  <= 8'h01;
		end else if (busy_q) begin
			state_q <= round_state(state_q, final_rnd) ^ rk_next;
			rk_q    <= rk_next;
			rcon_q  <= xtime(rcon_q);
		end
	end

	assign done = done_q;
	assign ct   = state_q;
endmodule

// ----- hdl/aes_davies_meyer_hash_mac.sv -----
// Davies-Meyer hash over AES-128 with an HMAC-like keyed sign/verify mode.
// Depends on dmh_pkg, dmh_stream_if and dmh_aes_core.
//
// Each compression runs on one round-iterative AES core: a load, ten rounds and a
// write-back of the chaining value. A block that is not last occupies the block for
// its accept in IDLE and one compression (two when it opens a keyed message, for the
// inner key block). A last block occupies its accept, one or two padding compressions
// and the DONE state that posts the tag; sign and verify add four compressions for
// the outer hash, and one more when the last block is also the first block of a
// keyed message. The input is not ready while a block is being worked on. A finished
// tag waits in an output register and the next message can be taken meanwhile, but
// that message cannot post its own tag until the register has been drained.
module aes_davies_meyer_hash_mac (
	input logic         clk,
	input logic         arst_n,
	dmh_stream_if.sink   blocks,
	dmh_stream_if.source tags,
	dmh_stream_if.sink   cfg
);
	import dmh_pkg::*;

	// Configuration registers.
	logic [1:0]  mode_q;
	logic [63:0] key_hi_q, key_lo_q, exp_hi_q, exp_lo_q;

	// Sequencer and message state.
	seq_state_t  st_q, st_d;
	logic        active_q;
	logic        keyed_q, verify_q;
	logic        run_q;
	blk_t        cv_q;
	blk_t        inner_q;
	blk_t        blk_q;
	logic [4:0]  n_q;
	logic        last_q;
	logic [63:0] len_q;

	// Output register.
	logic        out_valid_q;
	out_item_t   out_q;

	// AES core connection.
	logic        core_start;
	logic        core_done;
	blk_t        core_key;
	blk_t        core_ct;
	blk_t        cv_new;

	// Accept decode.
	logic        in_fire;
	in_item_t    item;
	logic        first_blk;
	logic        mode_keyed;
	logic [4:0]  n_sat;
	logic [63:0] len_base;
	logic        compressing;
	logic        inner_end;
	blk_t        tail0, tail1;
	blk_t        key_blk;

	assign item       = blocks.data;
	assign in_fire    = blocks.valid && blocks.ready;
	assign first_blk  = !active_q;
	assign mode_keyed = (mode_q == MODE_SIGN) || (mode_q == MODE_VERIFY);
	assign n_sat      = (item.byte_count > FULL_COUNT) ? FULL_COUNT : item.byte_count;
	assign len_base   = first_blk ? (mode_keyed ? 64'd16 : 64'd0) : len_q;
	assign key_blk    = {key_hi_q, key_lo_q};
	assign cv_new     = cv_q ^ core_ct;

	// Configuration writes.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PLAIN;
			key_hi_q <= 64'd0;
			key_lo_q <= 64'd0;
			exp_hi_q <= 64'd0;
			exp_lo_q <= 64'd0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_MODE:   mode_q   <= cfg.data.wdata[1:0];
				REG_KEY_HI: key_hi_q <= cfg.data.wdata;
				REG_KEY_LO: key_lo_q <= cfg.data.wdata;
				REG_EXP_HI: exp_hi_q <= cfg.data.wdata;
				REG_EXP_LO: exp_lo_q <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

	// Padding tail: message bytes, 0x80, zeros, then the length little-endian.
	always_comb begin
		logic [7:0] tb [32];
		logic [5:0] tlen;
		tlen = (n_q <= SHORT_TAIL_MAX) ? 6'd16 : 6'd32;
		for (int i = 0; i < 32; i++) begin
			if (i < 16 && 5'(i) < n_q) tb[i] = get_byte(blk_q, i % 16);
			else if (5'(i) == n_q) tb[i] = PAD_BYTE;
			else if (6'(i) >= tlen - 6'd8 && 6'(i) < tlen)
				tb[i] = len_q[8*(i % 8) +: 8];
			else tb[i] = 8'h00;
		end
		for (int i = 0; i < 16; i++) begin
			tail0[127 - 8*i -: 8] = tb[i];
			tail1[127 - 8*i -: 8] = tb[16 + i];
		end
	end

	// Message block for the current compression.
	always_comb begin
		compressing = 1'b1;
		case (st_q)
			ST_IPAD:      core_key = pad_xor(key_blk, IPAD_BYTE);
			ST_MSG:       core_key = blk_q;
			ST_TAIL0:     core_key = tail0;
			ST_TAIL1:     core_key = tail1;
			ST_OPAD:      core_key = pad_xor(key_blk, OPAD_BYTE);
			ST_OUTER:     core_key = inner_q;
			ST_OPAD_FIN,
			ST_OUTER_FIN: core_key = PAD16;
			default: begin
				core_key    = PAD16;
				compressing = 1'b0;
			end
		endcase
	end

	assign core_start = compressing && !run_q;
	assign inner_end  = core_done &&
		((st_q == ST_TAIL0 && n_q <= SHORT_TAIL_MAX) || st_q == ST_TAIL1);

	dmh_aes_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (core_start),
		.key    (core_key),
		.pt     (cv_q),
		.done   (core_done),
		.ct     (core_ct)
	);

	// Next state and handshake outputs.
	always_comb begin
		st_d = st_q;
		blocks.ready = (st_q == ST_IDLE);
		case (st_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (first_blk && mode_keyed) st_d = ST_IPAD;
					else if (item.last_block) st_d = ST_TAIL0;
					else st_d = ST_MSG;
				end
			end
			ST_IPAD:      if (core_done) st_d = last_q ? ST_TAIL0 : ST_MSG;
			ST_MSG:       if (core_done) st_d = ST_IDLE;
			ST_TAIL0: begin
				if (core_done) begin
					if (n_q > SHORT_TAIL_MAX) st_d = ST_TAIL1;
					else st_d = keyed_q ? ST_OPAD : ST_DONE;
				end
			end
			ST_TAIL1:     if (core_done) st_d = keyed_q ? ST_OPAD : ST_DONE;
			ST_OPAD:      if (core_done) st_d = ST_OPAD_FIN;
			ST_OPAD_FIN:  if (core_done) st_d = ST_OUTER;
			ST_OUTER:     if (core_done) st_d = ST_OUTER_FIN;
			ST_OUTER_FIN: if (core_done) st_d = ST_DONE;
			ST_DONE:      if (!out_valid_q) st_d = ST_IDLE;
			default:      st_d = ST_IDLE;
		endcase
	end

	// State register and control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			active_q    <= 1'b0;
			keyed_q     <= 1'b0;
			verify_q    <= 1'b0;
			run_q       <= 1'b0;
			out_valid_q <= 1'b0;
			cv_q        <= IV;
			len_q       <= 64'd0;
		end else begin
			st_q <= st_d;
			if (core_start) run_q <= 1'b1;
			else if (core_done) run_q <= 1'b0;

			if (in_fire) begin
				active_q <= 1'b1;
				len_q    <= len_base + (item.last_block ? 64'(n_sat) : 64'd16);
				if (first_blk) begin
					keyed_q  <= mode_keyed;
					verify_q <= (mode_q == MODE_VERIFY);
					cv_q     <= IV;
				end
			end

			// Chaining value write-back; the outer hash restarts from the IV.
			if (core_done) begin
				if (inner_end && keyed_q) cv_q <= IV;
				else cv_q <= cv_new;
			end

			if (tags.valid && tags.ready) out_valid_q <= 1'b0;
			if (st_q == ST_DONE && !out_valid_q) begin
				out_valid_q <= 1'b1;
				active_q    <= 1'b0;
				len_q       <= 64'd0;
				cv_q        <= IV;
			end
		end
	end

	// Held block, inner digest and output payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			blk_q  <= {item.block_high, item.block_low};
			n_q    <= n_sat;
			last_q <= item.last_block;
		end
		if (inner_end) inner_q <= cv_new;
		if (st_q == ST_DONE && !out_valid_q) begin
			out_q.tag_high  <= cv_q[127:64];
			out_q.tag_low   <= cv_q[63:0];
			out_q.tag_match <= verify_q && (cv_q == {exp_hi_q, exp_lo_q});
		end
	end

	assign tags.valid = out_valid_q;
	assign tags.data  = out_q;
endmodule

// ----- test/aes_davies_meyer_hash_mac_test.sv -----
// Self-checking testbench for the AES-128 Davies-Meyer hash and keyed sign/verify block.
// Depends on dmh_pkg, dmh_stream_if and aes_davies_meyer_hash_mac from hdl; predicts every tag with its own AES model.
`timescale 1ns / 1ps

import dmh_pkg::*;

// Tracks the hash state across blocks and works out the tag for each finished message.
class dm_tag_predictor;
	typedef enum {HP_IDLE, HP_PLAIN, HP_SIGN, HP_VERIFY} hash_phase_t;

	logic [1:0]  mode_reg;
	logic [63:0] key_hi, key_lo, exp_hi, exp_lo;
	blk_t        chain;
	logic [63:0] byte_total;
	hash_phase_t phase;

	function new();
		mode_reg = MODE_PLAIN;
		key_hi = '0;
		key_lo = '0;
		exp_hi = '0;
		exp_lo = '0;
		chain = IV;
		byte_total = '0;
		phase = HP_IDLE;
	endfunction

	function void set_reg(logic [2:0] idx, logic [63:0] val);
		case (idx)
			REG_MODE: mode_reg = val[1:0];
			REG_KEY_HI: key_hi = val;
			REG_KEY_LO: key_lo = val;
			REG_EXP_HI: exp_hi = val;
			REG_EXP_LO: exp_lo = val;
			default: ;
		endcase
	endfunction

	function logic [7:0] dbl(logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// Plain AES-128 encryption of one block, byte 0 in the top bits.
	function blk_t aes_encrypt(blk_t key, blk_t text);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] rk [16];
		logic [7:0] rc, a0, a1, a2, a3, sum, k0, k1, k2, k3;
		blk_t res;
		for (int i = 0; i < 16; i++) begin
			rk[i] = key[127-8*i -: 8];
			s[i] = text[127-8*i -: 8] ^ rk[i];
		end
		rc = 8'h01;
		for (int r = 1; r <= 10; r++) begin
			for (int i = 0; i < 16; i++) s[i] = SBOX[s[i]];
			for (int c = 0; c < 4; c++)
				for (int i = 0; i < 4; i++) t[i+4*c] = s[i + 4*((c+i) & 3)];
			if (r < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					sum = a0 ^ a1 ^ a2 ^ a3;
					t[4*c]   = a0 ^ sum ^ dbl(a0 ^ a1);
					t[4*c+1] = a1 ^ sum ^ dbl(a1 ^ a2);
					t[4*c+2] = a2 ^ sum ^ dbl(a2 ^ a3);
					t[4*c+3] = a3 ^ sum ^ dbl(a3 ^ a0);
				end
			end
			k0 = SBOX[rk[13]] ^ rc;
			k1 = SBOX[rk[14]];
			k2 = SBOX[rk[15]];
			k3 = SBOX[rk[12]];
			rk[0] ^= k0; rk[1] ^= k1; rk[2] ^= k2; rk[3] ^= k3;
			for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
			rc = dbl(rc);
			for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[i];
		end
		for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
		return res;
	endfunction

	// Davies-Meyer step: the message block is the cipher key.
	function blk_t compress(blk_t h, blk_t m);
		return aes_encrypt(m, h) ^ h;
	endfunction

	// Advances the state by one accepted block; returns 1 when a tag results.
	function bit step(in_item_t b, output out_item_t tag);
		blk_t h, o, keyb, mb;
		logic [255:0] tail;
		int n, tlen;
		keyb = {key_hi, key_lo};
		mb = {b.block_high, b.block_low};
		tag = '0;
		if (phase == HP_IDLE) begin
			h = IV;
			byte_total = '0;
			if (mode_reg == MODE_SIGN || mode_reg == MODE_VERIFY) begin
				h = compress(h, keyb ^ {16{IPAD_BYTE}});
				byte_total = 64'd16;
				phase = (mode_reg == MODE_SIGN) ? HP_SIGN : HP_VERIFY;
			end else begin
				phase = HP_PLAIN;
			end
		end else begin
			h = chain;
		end
		if (!b.last_block) begin
			chain = compress(h, mb);
			byte_total += 64'd16;
			return 0;
		end
		// Last block: pad with 0x80, zeros and the little-endian byte length.
		n = (b.byte_count > FULL_COUNT) ? 16 : int'(b.byte_count);
		byte_total += 64'(n);
		tail = '0;
		for (int i = 0; i < n; i++) tail[255-8*i -: 8] = mb[127-8*i -: 8];
		tail[255-8*n -: 8] = PAD_BYTE;
		tlen = (n <= 6) ? 16 : 32;
		for (int i = 0; i < 8; i++) tail[255-8*(tlen-8+i) -: 8] = byte_total[8*i +: 8];
		h = compress(h, tail[255:128]);
		if (tlen == 32) h = compress(h, tail[127:0]);
		if (phase == HP_SIGN || phase == HP_VERIFY) begin
			o = compress(IV, keyb ^ {16{OPAD_BYTE}});
			o = compress(o, PAD16);
			o = compress(o, h);
			h = compress(o, PAD16);
		end
		tag.tag_high = h[127:64];
		tag.tag_low = h[63:0];
		tag.tag_match = (phase == HP_VERIFY) && h == {exp_hi, exp_lo};
		phase = HP_IDLE;
		byte_total = '0;
		chain = IV;
		return 1;
	endfunction

	// Tag that a whole message would give from idle; the state ends idle again.
	function out_item_t preview(in_item_t msg [$]);
		out_item_t r;
		for (int i = 0; i < msg.size(); i++) void'(step(msg[i], r));
		return r;
	endfunction
endclass

// Holds the tags still owed by the block and compares each arriving one.
class tag_scoreboard;
	dm_tag_predictor pred;
	out_item_t       pending_tags [$];
	int              errors;
	int              tags_checked;

	function new();
		pred = new();
		errors = 0;
		tags_checked = 0;
	endfunction

	task report(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	function void note_block(in_item_t b);
		out_item_t r;
		if (pred.step(b, r)) pending_tags.insert(pending_tags.size(), r);
	endfunction

	task check_tag(out_item_t got);
		out_item_t want;
		if (pending_tags.size() == 0) begin
			report($sformatf("unexpected tag %h_%h", got.tag_high, got.tag_low));
			return;
		end
		want = pending_tags.pop_front();
		tags_checked++;
		if (got.tag_high !== want.tag_high)
			report($sformatf("tag_high %h, want %h", got.tag_high, want.tag_high));
		if (got.tag_low !== want.tag_low)
			report($sformatf("tag_low %h, want %h", got.tag_low, want.tag_low));
		if (got.tag_match !== want.tag_match)
			report($sformatf("tag_match %b, want %b", got.tag_match, want.tag_match));
	endtask
endclass

module aes_davies_meyer_hash_mac_test;
	localparam int CYCLE_LIMIT = 900000;
	localparam int SETTLE_CYCLES = 120;
	localparam int BLOCK_TARGET = 950;

	logic clk;
	logic arst_n;

	dmh_stream_if #(.payload_t(in_item_t))  blocks_if ();
	dmh_stream_if #(.payload_t(out_item_t)) tags_if ();
	dmh_stream_if #(.payload_t(cfg_item_t)) cfg_if ();

	aes_davies_meyer_hash_mac DUT (
		.clk(clk),
		.arst_n(arst_n),
		.blocks(blocks_if),
		.tags(tags_if),
		.cfg(cfg_if)
	);

	tag_scoreboard sb = new();
	in_item_t      msg [$];
	bit            quiet = 0;
	int            rx_hold = 0;
	int            blocks_sent = 0;
	int            messages_sent = 0;
	int            cycles = 0;

	// Clock and the single reset at the start of the run.
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Monitors: every accepted input beat feeds the predictor, every tag beat is checked.
	always @(posedge clk) begin
		if (arst_n && blocks_if.valid && blocks_if.ready) sb.note_block(blocks_if.data);
		if (arst_n && tags_if.valid && tags_if.ready) sb.check_tag(tags_if.data);
	end

	// Tag receiver: random stall bursts, plus long holds requested by the stimulus.
	initial begin
		int stall;
		stall = 0;
		tags_if.ready = 0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				tags_if.ready <= 0;
			end else if (stall > 0) begin
				stall--;
				tags_if.ready <= 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 4) - 1;
				tags_if.ready <= 0;
			end else begin
				tags_if.ready <= 1;
			end
		end
	end

	function automatic logic [63:0] rand_word();
		return {$urandom(), $urandom()};
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		cfg_if.valid <= 1;
		cfg_if.data <= '{index: idx, wdata: val};
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 0;
		sb.pred.set_reg(idx, val);
	endtask

	// Offers one block beat, with an occasional idle burst in front of it.
	task automatic send_block(in_item_t b);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			blocks_if.valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		blocks_if.valid <= 1;
		blocks_if.data <= b;
		@(posedge clk);
		while (!blocks_if.ready) @(posedge clk);
		blocks_sent++;
	endtask

	task automatic send_message();
		foreach (msg[i]) send_block(msg[i]);
		messages_sent++;
	endtask

	// Waits until every owed tag has arrived, then lets the block settle.
	task automatic drain();
		blocks_if.valid <= 0;
		@(posedge clk);
		while (sb.pending_tags.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Builds a message of full blocks and one last block with the given count.
	task automatic build_message(int full_blocks, logic [4:0] last_count);
		in_item_t b;
		msg.delete();
		for (int i = 0; i <= full_blocks; i++) begin
			b.block_high = rand_word();
			b.block_low = rand_word();
			b.byte_count = (i < full_blocks) ? 5'($urandom_range(0, 31)) : last_count;
			b.last_block = (i == full_blocks);
			msg.insert(msg.size(), b);
		end
	endtask

	task automatic set_mode_and_key(logic [1:0] m, logic [63:0] kh, logic [63:0] kl);
		write_reg(REG_MODE, 64'(m));
		write_reg(REG_KEY_HI, kh);
		write_reg(REG_KEY_LO, kl);
	endtask

	// Verify-mode message whose expected tag is set to match, or to miss by one bit.
	// The block is drained first so that the expected tag never changes under a message.
	task automatic verify_message(int full_blocks, logic [4:0] last_count, bit hit);
		out_item_t t;
		drain();
		build_message(full_blocks, last_count);
		t = sb.pred.preview(msg);
		if (!hit) t.tag_low[$urandom_range(0, 63)] ^= 1'b1;
		write_reg(REG_EXP_HI, t.tag_high);
		write_reg(REG_EXP_LO, t.tag_low);
		send_message();
		drain();
	endtask

	function automatic logic [4:0] rand_last_count();
		if ($urandom_range(0, 9) == 0) return 5'($urandom_range(17, 31));
		return 5'($urandom_range(0, 16));
	endfunction

	initial begin
		logic [1:0] m;
		logic [63:0] kh, kl;
		int phase_end;
		blocks_if.valid = 0;
		blocks_if.data = '0;
		cfg_if.valid = 0;
		cfg_if.data = '0;
		@(posedge arst_n);
		@(posedge clk);

		// Directed plain hashes: empty, padding boundaries, oversized count, extreme data.
		set_mode_and_key(MODE_PLAIN, '0, '0);
		write_reg(REG_EXP_HI, '1);
		write_reg(REG_EXP_LO, '1);
		build_message(0, 5'd0);
		send_message();
		build_message(0, 5'd6);
		send_message();
		build_message(0, 5'd7);
		send_message();
		build_message(0, FULL_COUNT);
		send_message();
		build_message(1, 5'd31);
		msg[0].block_high = '1;
		msg[0].block_low = '1;
		msg[1].block_high = '0;
		msg[1].block_low = '0;
		send_message();
		build_message(1, 5'd17);
		msg[0].block_high = '0;
		msg[0].block_low = '0;
		msg[1].block_high = '1;
		msg[1].block_low = '1;
		send_message();
		drain();

		// Unused mode code behaves as a plain hash.
		write_reg(REG_MODE, 64'd3);
		build_message(0, 5'd5);
		send_message();
		drain();

		// Keyed sign with the extreme keys.
		set_mode_and_key(MODE_SIGN, '0, '0);
		build_message(0, 5'd3);
		send_message();
		drain();
		set_mode_and_key(MODE_SIGN, '1, '1);
		build_message(1, 5'd0);
		send_message();
		drain();

		// Keyed verify: one matching expected tag, one that misses.
		set_mode_and_key(MODE_VERIFY, rand_word(), rand_word());
		verify_message(0, 5'd9, 1);
		verify_message(1, 5'd16, 0);

		// Random phases, each with its own mode and key, ending quiet.
		for (int ph = 0; blocks_sent < BLOCK_TARGET; ph++) begin
			m = (ph < 4) ? 2'(ph) : 2'($urandom_range(0, 3));
			kh = (ph == 5) ? '1 : (ph == 6) ? '0 : rand_word();
			kl = (ph == 5) ? '1 : (ph == 6) ? '0 : rand_word();
			set_mode_and_key(m, kh, kl);
			phase_end = blocks_sent + 110;
			if (ph == 2) rx_hold = 400;
			while (blocks_sent < phase_end && blocks_sent < BLOCK_TARGET) begin
				if (blocks_sent > BLOCK_TARGET - 100) quiet = 1;
				if (m == MODE_VERIFY && $urandom_range(0, 3) == 0) begin
					verify_message($urandom_range(0, 3), rand_last_count(),
						$urandom_range(0, 1));
				end else begin
					build_message(($urandom_range(0, 9) == 0) ? 8 : $urandom_range(0, 3),
						rand_last_count());
					send_message();
				end
			end
			drain();
		end

		$display("Sent %0d blocks in %0d messages over all four mode codes.",
			blocks_sent, messages_sent);
		$display("Checked %0d tags; %0d mismatches.", sb.tags_checked, sb.errors);
		if (sb.errors == 0 && sb.pending_tags.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
